[hdl/pgre_pkg.sv]
// Shared types, widths and register codes of the pixel gain reference estimator.
package pgre_pkg;

    localparam int unsigned MAX_PIXELS_DEFAULT = 65536;

    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 28;
    localparam int DIV_W    = 27;
    localparam int GAIN_W   = 32;
    localparam int IDX_W    = 16;
    localparam int LEN_W    = 17;
    localparam int TOL_W    = 15;
    localparam int PROD_W   = 44;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        REG_SAMPLE_FORMAT    = 2'd0,
        REG_PIXELS_PER_FRAME = 2'd1,
        REG_TOLERANCE        = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              fmt;
        logic [LEN_W-1:0]  len;
        logic [TOL_W-1:0]  tol;
    } cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        idx;
        logic                    last;
    } pix_item_t;

    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] value;
        logic [GAIN_W-1:0]       gain;
        logic [IDX_W-1:0]        idx;
        logic                    last;
        logic [PROD_W-1:0]       lo;
        logic [PROD_W-1:0]       hi;
        logic [DIV_W-1:0]        rem;
        logic [DIV_W-1:0]        dvd;
    } div_stage_t;

endpackage

[hdl/pgre_front.sv]
// Front end: sample conversion to Q11.16, pixel counting and frame end marking.
module pgre_front #(
    parameter int unsigned MAX_PIXELS = pgre_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    enable,
    input  pgre_pkg::cfg_t                          cfg,
    input  logic signed [pgre_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    output pgre_pkg::pix_item_t                     item,
    output logic                                    item_valid,
    input  logic                                    item_ready
);
    import pgre_pkg::*;

    localparam logic [LEN_W-1:0] CAP = LEN_W'((MAX_PIXELS < 65536) ? MAX_PIXELS : 65536);

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             accept;

    always_comb
    begin
        len        = ((cfg.len == '0) || (cfg.len > CAP)) ? CAP : cfg.len;
        last       = ({1'b0, cnt_reg} + LEN_W'(1)) >= len;
        item_valid = in_valid && enable;
        in_ready   = item_ready && enable;
        accept     = in_valid && in_ready;
        item.idx   = cnt_reg;
        item.last  = last;
        if (cfg.fmt == 1'b0)
        begin
            item.value = {{(VAL_W-24){sample[7]}}, sample[7:0], 16'h0000};
        end
        else
        begin
            item.value = {sample, 12'h000};
        end
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = last ? '0 : cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hdl/pgre_queue.sv]
// Two-entry queue that decouples the front end from the update pipeline.
module pgre_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  pgre_pkg::pix_item_t in_item,
    input  logic                in_valid,
    output logic                in_ready,
    output pgre_pkg::pix_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    import pgre_pkg::*;

    localparam int DEPTH = 2;

    pix_item_t data_reg [DEPTH];
    logic      wr_ptr_reg;
    logic      wr_ptr_next;
    logic      rd_ptr_reg;
    logic      rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic      push;
    logic      pop;

    always_comb
    begin
        in_ready    = (cnt_reg != 2'(DEPTH));
        out_valid   = (cnt_reg != 2'd0);
        out_item    = data_reg[rd_ptr_reg];
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[hdl/pgre_back.sv]
// Back end: gain map memory, pipelined remainder unit, update rule and result register.
module pgre_back #(
    parameter int unsigned MAX_PIXELS = pgre_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pgre_pkg::cfg_t                          cfg,
    input  pgre_pkg::pix_item_t                     item,
    input  logic                                    item_valid,
    output logic                                    item_ready,
    output logic                                    busy,
    output logic signed [pgre_pkg::GAIN_W-1:0]      gain_value,
    output logic [pgre_pkg::IDX_W-1:0]              pixel_index,
    output logic                                    frame_end,
    output logic                                    out_valid,
    input  logic                                    out_ready
);
    import pgre_pkg::*;

    localparam int unsigned DEPTH = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NDIV = DIV_W;

    function automatic logic [AW-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [AW-1:0] s;
        s = '0;
        if ({1'b0, idx} < LEN_W'(DEPTH))
        begin
            s = AW'(idx);
        end
        return s;
    endfunction

    logic [GAIN_W-1:0] mem [DEPTH];

    logic              clearing_reg;
    logic              clearing_next;
    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     clr_addr_next;

    logic              p0_vld_reg;
    pix_item_t         p0_item_reg;
    logic [GAIN_W-1:0] rd_data_reg;

    div_stage_t        st_reg  [NDIV+1];
    div_stage_t        st_next [NDIV+1];

    logic              out_vld_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              last_reg;

    logic              en;
    logic              hazard;
    logic              pop;
    logic [AW-1:0]     head_slot;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [GAIN_W-1:0] wr_data;
    logic [GAIN_W-1:0] result;
    logic [PROD_W-1:0] rs;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    divisor;
    div_stage_t        fin;

    always_comb
    begin
        en        = !out_vld_reg || out_ready;
        head_slot = slot_of(item.idx);
        hazard    = p0_vld_reg && (slot_of(p0_item_reg.idx) == head_slot);
        for (int k = 0; k <= NDIV; k++)
        begin
            if (st_reg[k].vld && (slot_of(st_reg[k].idx) == head_slot))
            begin
                hazard = 1'b1;
            end
        end
        pop        = en && item_valid && !hazard && !clearing_reg;
        item_ready = pop;
        busy       = clearing_reg;

        // Entry to the remainder pipeline: gain from memory and both thresholds.
        st_next[0].vld   = p0_vld_reg;
        st_next[0].value = p0_item_reg.value;
        st_next[0].gain  = rd_data_reg;
        st_next[0].idx   = p0_item_reg.idx;
        st_next[0].last  = p0_item_reg.last;
        st_next[0].lo    = PROD_W'(cfg.tol) * PROD_W'(rd_data_reg[DIV_W-1:0]);
        st_next[0].hi    = PROD_W'(LEN_W'(65536) - LEN_W'(cfg.tol))
                           * PROD_W'(rd_data_reg[DIV_W-1:0]);
        st_next[0].rem   = '0;
        st_next[0].dvd   = p0_item_reg.value[DIV_W-1:0];

        // One restoring step per stage.
        for (int k = 1; k <= NDIV; k++)
        begin
            st_next[k] = st_reg[k-1];
            trial      = {st_reg[k-1].rem, st_reg[k-1].dvd[DIV_W-1]};
            divisor    = {1'b0, st_reg[k-1].gain[DIV_W-1:0]};
            if (trial >= divisor)
            begin
                st_next[k].rem = DIV_W'(trial - divisor);
            end
            else
            begin
                st_next[k].rem = trial[DIV_W-1:0];
            end
            st_next[k].dvd = {st_reg[k-1].dvd[DIV_W-2:0], 1'b0};
        end

        // Update rule on the finished remainder.
        fin = st_reg[NDIV];
        rs  = {1'b0, fin.rem, 16'h0000};
        if ($signed(fin.gain) <= 0)
        begin
            result = {{(GAIN_W-VAL_W){fin.value[VAL_W-1]}}, fin.value};
        end
        else if (fin.value[VAL_W-1])
        begin
            result = fin.gain;
        end
        else if ((rs > fin.lo) && (rs < fin.hi))
        begin
            result = GAIN_W'(fin.rem);
        end
        else if (rs >= fin.hi)
        begin
            result = (GAIN_W'(fin.rem) + fin.gain) >> 1;
        end
        else
        begin
            result = fin.gain;
        end

        wr_en   = clearing_reg || (en && fin.vld);
        wr_addr = clearing_reg ? clr_addr_reg : slot_of(fin.idx);
        wr_data = clearing_reg ? '0 : result;

        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        out_valid   = out_vld_reg;
        gain_value  = gain_reg;
        pixel_index = idx_reg;
        frame_end   = last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (en)
        begin
            rd_data_reg <= mem[head_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_item_reg <= item;
            if (fin.vld)
            begin
                gain_reg <= result;
                idx_reg  <= fin.idx;
                last_reg <= fin.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            p0_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int k = 0; k <= NDIV; k++)
            begin
                st_reg[k] <= '0;
            end
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            if (en)
            begin
                p0_vld_reg  <= pop;
                out_vld_reg <= fin.vld;
                for (int k = 0; k <= NDIV; k++)
                begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    end

endmodule

[hdl/pixel_gain_reference_estimator_unit.sv]
// Top level of the pixel gain reference estimator with its configuration registers.
//
// The block takes one detector sample per clock in raster order unless stalled,
// converts it to signed Q11.16 and refines the gain stored for that pixel: a
// non-positive gain is replaced by the sample, a negative sample leaves it
// unchanged, otherwise the remainder of the sample modulo the gain replaces it,
// averages with it, or leaves it unchanged, depending on where the remainder
// falls against the tolerance band. Each accepted input transaction gives
// exactly one output transaction with the new gain, the pixel index and a frame
// end flag. Throughput is one pixel per clock unless stalled. Each pixel passes
// the queue write at acceptance, then the memory read, the threshold stage, the
// 27 remainder stages and the result register. When a frame has fewer than 30
// pixels, a pixel whose gain is still being updated holds the next one of the
// same slot back until its write lands, so such frames run at one pipeline pass
// per frame. After reset the gain map of min(MAX_PIXELS, 65536) words is cleared
// one word per cycle, and no sample is accepted until that pass ends;
// configuration writes are taken throughout.
module pixel_gain_reference_estimator_unit #(
    parameter int unsigned MAX_PIXELS = pgre_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pgre_pkg::PADDR_W-1:0]            paddr,
    input  logic [pgre_pkg::PDATA_W-1:0]            pwdata,
    output logic [pgre_pkg::PDATA_W-1:0]            prdata,
    output logic                                    pready,
    input  logic signed [pgre_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    output logic signed [pgre_pkg::GAIN_W-1:0]      gain_value,
    output logic [pgre_pkg::IDX_W-1:0]              pixel_index,
    output logic                                    frame_end,
    output logic                                    out_valid,
    input  logic                                    out_ready
);
    import pgre_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    reg_idx_t  reg_sel;
    logic      busy;
    pix_item_t front_item;
    logic      front_valid;
    logic      front_ready;
    pix_item_t queue_item;
    logic      queue_valid;
    logic      queue_ready;

    // Register decode: index from the word address; unknown indexes are ignored.
    always_comb
    begin
        pready   = 1'b1;
        reg_sel  = reg_idx_t'(paddr[3:2]);
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_sel)
            REG_SAMPLE_FORMAT:
            begin
                prdata = PDATA_W'(cfg_reg.fmt);
                if (psel && penable && pwrite)
                begin
                    cfg_next.fmt = pwdata[0];
                end
            end
            REG_PIXELS_PER_FRAME:
            begin
                prdata = PDATA_W'(cfg_reg.len);
                if (psel && penable && pwrite)
                begin
                    cfg_next.len = pwdata[LEN_W-1:0];
                end
            end
            REG_TOLERANCE:
            begin
                prdata = PDATA_W'(cfg_reg.tol);
                if (psel && penable && pwrite)
                begin
                    cfg_next.tol = pwdata[TOL_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt <= 1'b1;
            cfg_reg.len <= LEN_W'(65536);
            cfg_reg.tol <= TOL_W'(7);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end converts and numbers the pixels.
    pgre_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (!busy),
        .cfg        (cfg_reg),
        .sample     (sample),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    // The queue lets the front take up to two transactions while the back stalls.
    pgre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (front_item),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_item  (queue_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    // The back end reads the gain, runs the remainder pipeline and writes back.
    pgre_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item        (queue_item),
        .item_valid  (queue_valid),
        .item_ready  (queue_ready),
        .busy        (busy),
        .gain_value  (gain_value),
        .pixel_index (pixel_index),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

[sim/tb_pixel_gain_reference_estimator_unit.sv]
// Self-checking testbench for the pixel gain reference estimator top level.
module tb_pixel_gain_reference_estimator_unit;
    import pgre_pkg::*;

    // One expected output transaction: new gain, raster index and frame end flag.
    typedef struct {
        logic signed [31:0] gain;
        logic [15:0]        idx;
        logic               last;
    } gain_result_t;

    // The scoreboard keeps its own copy of the gain map, the pixel counter and the
    // registers, computes the result of every accepted sample and queues it.
    class gain_scoreboard;
        logic signed [31:0] gain_map [0:65535];
        logic [15:0]        pixel_count;
        logic               fmt;
        logic [16:0]        frame_len;
        logic [14:0]        tol;
        gain_result_t       pending [$];
        int                 errors;

        function void clear();
            foreach (gain_map[i]) gain_map[i] = 0;
            pixel_count = 0;
            fmt = 1'b1;
            frame_len = 17'd65536;
            tol = 15'd7;
            errors = 0;
        endfunction

        function void write_reg(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_SAMPLE_FORMAT:    fmt = v[0];
                REG_PIXELS_PER_FRAME: frame_len = v[16:0];
                REG_TOLERANCE:        tol = v[14:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [15:0] raw);
            longint v, g, r, rs, lo, hi, ng, len;
            gain_result_t res;
            len = (frame_len == 0 || frame_len > 65536) ? 65536 : frame_len;
            if (fmt == 1'b0)
                v = longint'($signed(raw[7:0])) * 65536;
            else
                v = longint'($signed(raw)) * 4096;
            g = gain_map[pixel_count];
            if (g <= 0)
                ng = v;
            else
            begin
                r = v % g;
                rs = r * 65536;
                lo = longint'(tol) * g;
                hi = (65536 - longint'(tol)) * g;
                if (rs > lo && rs < hi)
                    ng = r;
                else if (rs >= hi)
                    ng = (r + g) / 2;
                else
                    ng = g;
            end
            gain_map[pixel_count] = ng[31:0];
            res.gain = ng[31:0];
            res.idx = pixel_count;
            res.last = (longint'(pixel_count) + 1) >= len;
            pending.push_back(res);
            pixel_count = res.last ? 16'd0 : pixel_count + 16'd1;
        endfunction

        function void check_result(logic signed [31:0] g, logic [15:0] idx, logic last);
            gain_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: gain_value %0d pixel_index %0d", g, idx);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (g !== e.gain)
            begin
                $error("gain_value: expected %0d, actual %0d", e.gain, g);
                errors++;
            end
            if (idx !== e.idx)
            begin
                $error("pixel_index: expected %0d, actual %0d", e.idx, idx);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("frame_end: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic signed [SAMPLE_W-1:0] sample;
    logic in_valid;
    logic in_ready;
    logic signed [GAIN_W-1:0] gain_value;
    logic [IDX_W-1:0] pixel_index;
    logic frame_end;
    logic out_valid;
    logic out_ready;

    gain_scoreboard board;
    // Idling is switched off for the last part of the run.
    bit calm;
    // While set, the receiver holds off completely so the pipeline fills.
    bit hold_output;

    pixel_gain_reference_estimator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample(sample), .in_valid(in_valid), .in_ready(in_ready),
        .gain_value(gain_value), .pixel_index(pixel_index), .frame_end(frame_end),
        .out_valid(out_valid), .out_ready(out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Fixed guard time, far above the slowest correct run including the clearing
    // pass after reset and the single-pixel frames that run one pipeline pass each.
    initial
    begin
        #4000000;
        $display("tb_pixel_gain_reference_estimator_unit: FAIL");
        $finish;
    end

    // Output side: every transaction seen at a rising edge is checked right there.
    // The ready line stalls in random bursts unless the run is in its calm part.
    initial
    begin
        int burst;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(gain_value, pixel_index, frame_end);
            if (hold_output)
                out_ready <= 1'b0;
            else if (burst > 0)
            begin
                burst--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Two-phase register write; the scoreboard takes the value at the access edge.
    task automatic write_reg(reg_idx_t r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(r));
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.write_reg(r, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offers one sample, sometimes idles in a random burst first, and waits for acceptance.
    task automatic send_sample(logic [15:0] raw);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= raw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_sample(raw);
    endtask

    // Lowers valid and waits until every queued result has come back, then lets
    // the pipeline settle before registers may change.
    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    // Samples mostly come from small value ranges so that every update
    // branch is taken, with some fully random and negative values mixed in.
    function automatic logic [15:0] pick_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return 16'($urandom);
        else if (k < 5)
            return 16'($urandom_range(0, 4095));
        else if (k < 7)
            return {8'($urandom), 8'($urandom_range(0, 127))};
        else if (k < 8)
            return 16'(-int'($urandom_range(1, 200)));
        else
            return 16'($urandom_range(16, 400));
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_sample(pick_sample());
        drain();
    endtask

    initial
    begin
        board = new();
        board.clear();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample = '0;
        in_valid = 1'b0;
        calm = 1'b0;
        hold_output = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: small frame, extremes of both formats, negative values.
        write_reg(REG_PIXELS_PER_FRAME, 32'd4);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h0100);
        send_sample(16'h8000);
        send_sample(16'h0003);
        send_sample(16'h0000);
        send_sample(16'h0150);
        send_sample(16'hFF00);
        send_sample(16'h0011);
        send_sample(16'h5555);
        drain();
        write_reg(REG_SAMPLE_FORMAT, 32'd0);
        write_reg(REG_TOLERANCE, 32'd32767);
        send_sample(16'h007F);
        send_sample(16'h0080);
        send_sample(16'hAA01);
        send_sample(16'h00FF);
        send_sample(16'h0033);
        send_sample(16'h0005);
        drain();
        // A frame length of zero falls back to the full map size.
        write_reg(REG_PIXELS_PER_FRAME, 32'd0);
        write_reg(REG_TOLERANCE, 32'd0);
        send_sample(16'h0040);
        send_sample(16'h0007);
        drain();

        // Frame shrunk mid-frame: counter already beyond the new length.
        write_reg(REG_PIXELS_PER_FRAME, 32'd1);
        write_reg(REG_SAMPLE_FORMAT, 32'd1);
        write_reg(REG_TOLERANCE, 32'd7);
        random_phase(30);

        // Random phases through several settings, extremes among them.
        write_reg(REG_PIXELS_PER_FRAME, 32'd7);
        random_phase(300);
        write_reg(REG_TOLERANCE, 32'd6554);
        write_reg(REG_PIXELS_PER_FRAME, 32'd40);
        random_phase(300);
        write_reg(REG_SAMPLE_FORMAT, 32'd0);
        write_reg(REG_TOLERANCE, 32'($urandom_range(0, 32767)));
        // Oversized value keeps only the low 17 bits, here 65536.
        write_reg(REG_PIXELS_PER_FRAME, 32'h0003_0000);
        random_phase(200);
        write_reg(REG_PIXELS_PER_FRAME, 32'd13);
        write_reg(REG_TOLERANCE, 32'd32767);
        random_phase(250);

        // Back-pressure: hold the output off while the sender keeps offering.
        write_reg(REG_SAMPLE_FORMAT, 32'd1);
        write_reg(REG_TOLERANCE, 32'd3);
        write_reg(REG_PIXELS_PER_FRAME, 32'd64);
        fork
            begin
                hold_output = 1'b1;
                repeat (150) @(posedge clk);
                hold_output = 1'b0;
            end
            repeat (120) send_sample(pick_sample());
        join
        drain();

        // Final part without any idling.
        calm = 1'b1;
        write_reg(REG_PIXELS_PER_FRAME, 32'd37);
        random_phase(450);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_pixel_gain_reference_estimator_unit: PASS");
        else
        begin
            if (board.pending.size() != 0)
                $error("%0d expected results never arrived", board.pending.size());
            $display("tb_pixel_gain_reference_estimator_unit: FAIL");
        end
        $finish;
    end
endmodule
